FILE: design/tte_pkg.sv
package tte_pkg;

  // table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  // field widths
  localparam int ID_W     = 16;
  localparam int PMS_W    = 31;
  localparam int PERIOD_W = 51;
  localparam int TIME_W   = 64;

  localparam logic [PERIOD_W-1:0] NS_PER_MS = PERIOD_W'(1000000);

  // action codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_START  = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;
  localparam logic [2:0] ACT_TICK   = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_FIRED     = 3'd3;
  localparam logic [2:0] KIND_TICK_DONE = 3'd4;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   rem;
    logic [TIME_W-1:0]   stamp;
    logic                oneshot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_RD,
    ST_CHK,
    ST_UPD,
    ST_PRD,
    ST_PWR,
    ST_CMD,
    ST_NEXT,
    ST_FIN
  } state_t;

endpackage

FILE: design/tte_if.sv
interface tte_in_if;
  import tte_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [ID_W-1:0]     target_id;
  logic [PMS_W-1:0]    period_ms;
  logic                one_shot;
  logic [TIME_W-1:0]   now_ns;

  modport source (output valid, action, target_id, period_ms, one_shot, now_ns,
                  input ready);
  modport sink (input valid, action, target_id, period_ms, one_shot, now_ns,
                output ready);
endinterface

interface tte_out_if;
  import tte_pkg::*;
  logic            valid;
  logic            ready;
  logic [2:0]      kind;
  logic [ID_W-1:0] result_id;
  logic            found;
  logic            is_one_shot;
  logic            last;

  modport source (output valid, kind, result_id, found, is_one_shot, last,
                  input ready);
  modport sink (input valid, kind, result_id, found, is_one_shot, last,
                output ready);
endinterface

FILE: design/timer_table_engine.sv
// add multiplies the period and writes the new entry; remove/start/stop/query read the slots
//   in turn until the id is found; an empty table or an unknown action goes straight to the result
// tick reads every active slot, updates the running ones that advanced, and purges expired
//   slots marked for removal by moving the last entry into their place
// the slots are visited one at a time through the single read port of the entry memory
// one item in flight at a time; results wait in an output register
// reset (synchronous, active low) empties the table and clears the id counter
module timer_table_engine (
  input logic       clk,
  input logic       rst_n,
  tte_in_if.sink    in_ch,
  tte_out_if.source out_ch
);
  import tte_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0]          act_r;
  logic [ID_W-1:0]     tid_r;
  logic [PMS_W-1:0]    pms_r;
  logic                os_r;
  logic [TIME_W-1:0]   now_r;
  logic [PERIOD_W-1:0] prod_r;
  logic [IDX_W-1:0]    idx_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ID_W-1:0]     nid_r;
  logic [TABLE_SLOTS-1:0] run_r, mark_r;
  entry_t              ent_r;
  logic [TIME_W-1:0]   diff_r;

  logic            out_valid_r;
  logic [2:0]      kind_r;
  logic [ID_W-1:0] rid_r;
  logic            found_r, oso_r, last_r;

  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  logic [ENTRY_W-1:0] mem_rbits;

  logic            emit;
  logic [2:0]      e_kind;
  logic [ID_W-1:0] e_id;
  logic            e_found, e_os, e_last;

  logic             in_xfer, out_free, has_room, more, hit, skip, expired;
  logic [IDX_W-1:0] last_idx;
  logic [TIME_W-1:0] rem_n;

  tte_ram #(.DEPTH(TABLE_SLOTS), .WIDTH(ENTRY_W), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rbits)
  );
  assign mem_rdata = entry_t'(mem_rbits);

  // handshake and shared conditions
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign has_room    = cnt_r < CNT_W'(TABLE_SLOTS);
  assign more        = (CNT_W'(idx_r) + CNT_W'(1)) < cnt_r;
  assign last_idx    = IDX_W'(cnt_r - CNT_W'(1));
  assign hit         = mem_rdata.id == tid_r;
  assign skip        = !run_r[idx_r] || !(mem_rdata.stamp < now_r);
  assign rem_n       = ent_r.rem - diff_r;
  assign expired     = (rem_n == '0) || rem_n[TIME_W-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action == ACT_ADD) begin
            state_nxt = ST_MUL;
          end else if (in_ch.action inside {[ACT_REMOVE:ACT_TICK]}) begin
            state_nxt = (cnt_r == '0) ? ST_FIN : ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  if (out_free) state_nxt = ST_IDLE;
      ST_RD:   state_nxt = ST_CHK;
      ST_CHK: begin
        if (act_r == ACT_TICK) begin
          state_nxt = skip ? ST_NEXT : ST_UPD;
        end else begin
          state_nxt = hit ? ST_CMD : ST_NEXT;
        end
      end
      ST_UPD: begin
        if (!expired) begin
          state_nxt = ST_NEXT;
        end else if (mark_r[idx_r]) begin
          state_nxt = ST_PRD;
        end else if (out_free) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_PRD:  state_nxt = ST_PWR;
      ST_PWR:  state_nxt = ST_NEXT;
      ST_CMD:  if (out_free) state_nxt = ST_IDLE;
      ST_NEXT: state_nxt = more ? ST_RD : ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory access and result generation
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = ent_r;
    mem_raddr = idx_r;
    emit      = 1'b0;
    e_kind    = KIND_DONE;
    e_id      = '0;
    e_found   = 1'b0;
    e_os      = 1'b0;
    e_last    = 1'b1;
    case (state_r)
      ST_ADD: begin
        if (out_free) begin
          emit = 1'b1;
          if (has_room) begin
            mem_we            = 1'b1;
            mem_waddr         = IDX_W'(cnt_r);
            mem_wdata.id      = nid_r;
            mem_wdata.period  = prod_r;
            mem_wdata.rem     = '0;
            mem_wdata.stamp   = '0;
            mem_wdata.oneshot = os_r;
            e_kind            = KIND_ADDED;
            e_id              = nid_r;
          end else begin
            e_kind = KIND_FULL;
          end
        end
      end
      ST_UPD: begin
        mem_wdata.stamp = now_r;
        if (!expired) begin
          mem_we        = 1'b1;
          mem_wdata.rem = rem_n;
        end else if (!mark_r[idx_r] && out_free) begin
          mem_we        = 1'b1;
          mem_wdata.rem = ent_r.oneshot ? rem_n : TIME_W'(ent_r.period);
          emit          = 1'b1;
          e_kind        = KIND_FIRED;
          e_id          = ent_r.id;
          e_last        = 1'b0;
        end
      end
      ST_PRD: mem_raddr = last_idx;
      ST_PWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      ST_CMD: begin
        if (out_free) begin
          emit    = 1'b1;
          e_id    = tid_r;
          e_found = 1'b1;
          e_os    = (act_r == ACT_QUERY) && ent_r.oneshot;
          if (act_r == ACT_START) begin
            mem_we          = 1'b1;
            mem_wdata.rem   = TIME_W'(ent_r.period);
            mem_wdata.stamp = now_r;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (act_r == ACT_TICK) begin
            e_kind = KIND_TICK_DONE;
          end else begin
            e_id = tid_r;
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      nid_r       <= '0;
      run_r       <= '0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: if (in_xfer) idx_r <= '0;
        ST_ADD: begin
          if (out_free && has_room) begin
            run_r[IDX_W'(cnt_r)]  <= 1'b0;
            mark_r[IDX_W'(cnt_r)] <= 1'b0;
            cnt_r                 <= cnt_r + CNT_W'(1);
            nid_r                 <= nid_r + ID_W'(1);
          end
        end
        ST_UPD: begin
          if (expired && !mark_r[idx_r] && out_free && ent_r.oneshot) begin
            run_r[idx_r] <= 1'b0;
          end
        end
        ST_PWR: begin
          // move the last entry's flags in, then clear the vacated slot
          if (idx_r != last_idx) begin
            run_r[idx_r]  <= run_r[last_idx];
            mark_r[idx_r] <= mark_r[last_idx];
          end
          run_r[last_idx]  <= 1'b0;
          mark_r[last_idx] <= 1'b0;
          cnt_r            <= cnt_r - CNT_W'(1);
        end
        ST_CMD: begin
          if (out_free) begin
            case (act_r)
              ACT_REMOVE: mark_r[idx_r] <= 1'b1;
              ACT_START:  run_r[idx_r]  <= 1'b1;
              ACT_STOP:   run_r[idx_r]  <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_NEXT: idx_r <= idx_r + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r <= in_ch.action;
      tid_r <= in_ch.target_id;
      pms_r <= in_ch.period_ms;
      os_r  <= in_ch.one_shot;
      now_r <= in_ch.now_ns;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PERIOD_W'(pms_r) * NS_PER_MS;
    end
    if (state_r == ST_CHK) begin
      ent_r  <= mem_rdata;
      diff_r <= now_r - mem_rdata.stamp;
    end
    if (emit) begin
      kind_r  <= e_kind;
      rid_r   <= e_id;
      found_r <= e_found;
      oso_r   <= e_os;
      last_r  <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.result_id   = rid_r;
  assign out_ch.found       = found_r;
  assign out_ch.is_one_shot = oso_r;
  assign out_ch.last        = last_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_SLOTS))
    else $error("active count beyond table size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_we)
    else $error("memory write while idle");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("new transfer taken during work");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwritten before transfer");

endmodule

FILE: design/tte_ram.sv
module tte_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
